@@ sv/clock_of_clocks_hand_animator_top_defines.svh @@
// assertion helpers used by the top module
`ifndef CLOCK_OF_CLOCKS_HAND_ANIMATOR_TOP_DEFINES_SVH
`define CLOCK_OF_CLOCKS_HAND_ANIMATOR_TOP_DEFINES_SVH

// same-cycle implication
`define COCHA_ASSERT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("cocha assertion failed");

// next-cycle implication
`define COCHA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("cocha assertion failed");

`endif

@@ sv/cocha_pkg.sv @@
package cocha_pkg;

    typedef enum logic [1:0] {
        CMD_SET  = 2'd0,
        CMD_TICK = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_READ,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [16:0] ang_a;
        logic [16:0] ang_b;
    } t_pair;

    localparam int unsigned ANGLE_W    = 17;
    localparam logic [16:0] ANGLE_RESET = 17'd34560;
    localparam logic [16:0] DEG_0      = 17'd0;
    localparam logic [16:0] DEG_90     = 17'd23040;
    localparam logic [16:0] DEG_135    = 17'd34560;
    localparam logic [16:0] DEG_180    = 17'd46080;
    localparam logic [16:0] DEG_270    = 17'd69120;
    localparam logic [17:0] FULL_TURN  = 18'd92160;
    localparam logic signed [17:0] S_FULL = 18'sd92160;
    localparam logic signed [17:0] S_HALF = 18'sd46080;
    localparam logic [15:0] SNAP_LIMIT = 16'd128;
    localparam logic [16:0] UNIT_Q16   = 17'd65536;
    localparam logic [7:0]  RATE_RESET = 8'd10;
    localparam logic [3:0]  DIGIT_BLANK = 4'd10;

    // glyph symbols
    localparam logic [7:0] CH_DASH = "-";
    localparam logic [7:0] CH_BAR  = "|";
    localparam logic [7:0] CH_A    = "a";
    localparam logic [7:0] CH_B    = "b";
    localparam logic [7:0] CH_C    = "c";
    localparam logic [7:0] CH_D    = "d";

    // one 24-symbol glyph per decimal digit, row major, first symbol in the msbs
    localparam logic [0:9][191:0] GLYPH_TEXT = '{
        {"a--b", "|ab|", "||||", "||||", "|cd|", "c--d"},
        {"a-b ", "cb| ", " || ", " || ", "adcb", "c--d"},
        {"a--b", "c-b|", "a-d|", "|a-d", "|c-b", "c--d"},
        {"a--b", "c-b|", " ad|", " cb|", "a-d|", "c--d"},
        {"abab", "||||", "|cd|", "c-b|", "  ||", "  cd"},
        {"a--b", "|a-d", "|c-b", "c-b|", "a-d|", "c--d"},
        {"a--b", "|a-d", "|c-b", "|ab|", "|cd|", "c--d"},
        {"a--b", "c-b|", "  ||", "  ||", "  ||", "  cd"},
        {"a--b", "|ab|", "|cd|", "|ab|", "|cd|", "c--d"},
        {"a--b", "|ab|", "|cd|", "c-b|", "a-d|", "c--d"}
    };

    function automatic t_pair glyph_pair(input logic [3:0] value, input logic [4:0] pos);
        logic [7:0] ch;
        t_pair      p;
        ch = " ";
        if (value <= 4'd9 && pos <= 5'd23) begin
            ch = GLYPH_TEXT[value][8 * (23 - int'(pos)) +: 8];
        end
        case (ch)
            CH_DASH: p = '{ang_a: DEG_0,   ang_b: DEG_180};
            CH_BAR:  p = '{ang_a: DEG_90,  ang_b: DEG_270};
            CH_A:    p = '{ang_a: DEG_0,   ang_b: DEG_90};
            CH_B:    p = '{ang_a: DEG_90,  ang_b: DEG_180};
            CH_C:    p = '{ang_a: DEG_0,   ang_b: DEG_270};
            CH_D:    p = '{ang_a: DEG_180, ang_b: DEG_270};
            default: p = '{ang_a: DEG_135, ang_b: DEG_135};
        endcase
        return p;
    endfunction

    // tens digit of a value below 64, by compare chain
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    function automatic logic [3:0] ones_of(input logic [5:0] v);
        logic [6:0] tenfold;
        logic [6:0] rest;
        tenfold = 7'(tens_of(v)) * 7'd10;
        rest    = {1'b0, v} - tenfold;
        return rest[3:0];
    endfunction

endpackage

@@ sv/cocha_in_if.sv @@
interface cocha_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [15:0] frame_time;
    logic [8:0]  hand_index;

    modport source (
        output valid, command, hours, minutes, seconds, frame_time, hand_index,
        input  ready
    );
    modport sink (
        input  valid, command, hours, minutes, seconds, frame_time, hand_index,
        output ready
    );
endinterface

@@ sv/cocha_out_if.sv @@
interface cocha_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] hand_angle;
    logic [8:0]  hands_moving;

    modport source (
        output valid, hand_angle, hands_moving,
        input  ready
    );
    modport sink (
        input  valid, hand_angle, hands_moving,
        output ready
    );
endinterface

@@ sv/cocha_cfg_if.sv @@
interface cocha_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] animation_rate;

    modport source (
        output valid, animation_rate,
        input  ready
    );
    modport sink (
        input  valid, animation_rate,
        output ready
    );
endinterface

@@ sv/cocha_ram.sv @@
module cocha_ram #(
    parameter int unsigned WIDTH = 17,
    parameter int unsigned DEPTH = 288
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/clock_of_clocks_hand_animator_top.sv @@
// clock of clocks hand animator
// i_in takes one command item: set time (loads glyph targets for every hand),
// tick (eases every hand toward its target by frame_time * animation_rate),
// read (returns one hand's angle) or no operation. every item gives exactly
// one result on o_out: the read angle (zero otherwise) and the count of hands
// still away from their target. i_cfg writes animation_rate at any time the
// block is idle; it is always ready.
// set time and tick sweep all hands through one shared easing pipeline fed by
// one read port of each angle memory, one hand issued a cycle with a single
// memory read and write per hand; the result waits until the pipeline drains.
// read passes through a read state before the result state; no operation
// goes straight from idle to the result state.
// after reset a clearing pass writes 135 degrees into both angle memories, one
// hand a cycle, over all HAND_TOTAL hands; i_in is not ready meanwhile.
// the result sits in an output register: a new item is accepted while it
// waits, and the next item holds its result back until o_out.ready frees it.
`include "clock_of_clocks_hand_animator_top_defines.svh"

module clock_of_clocks_hand_animator_top #(
    parameter int unsigned DIGIT_COUNT   = 6,
    parameter int unsigned GLYPH_ROWS    = 6,
    parameter int unsigned GLYPH_COLUMNS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cocha_in_if.sink    i_in,
    cocha_out_if.source o_out,
    cocha_cfg_if.sink   i_cfg
);
    import cocha_pkg::*;

    localparam int unsigned HAND_TOTAL = DIGIT_COUNT * GLYPH_ROWS * GLYPH_COLUMNS * 2;
    localparam int unsigned HW   = $clog2(HAND_TOTAL);
    localparam int unsigned CNTW = $clog2(HAND_TOTAL + 1);
    localparam int unsigned DW   = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int unsigned RW   = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
    localparam int unsigned CW   = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
    localparam int unsigned IXW  = (HW > 9) ? HW : 9;

    t_state r_state, n_state;
    t_cmd   r_cmd;

    logic [7:0]      r_rate;
    logic [16:0]     r_factor;
    logic [3:0]      r_digits [6];
    logic [HW-1:0]   r_issue_idx;
    logic [DW-1:0]   r_dig;
    logic [RW-1:0]   r_row;
    logic [CW-1:0]   r_col;
    logic            r_hand;
    logic [CNTW-1:0] r_count;
    logic [16:0]     r_angle;
    logic            r_read_ok;
    logic            r_out_valid;
    logic [16:0]     r_out_angle;
    logic [8:0]      r_out_moving;

    // easing pipeline
    logic            r_p1_valid;
    logic [HW-1:0]   r_p1_idx;
    logic [16:0]     r_p1_glyph;
    logic            r_p2_valid;
    logic [HW-1:0]   r_p2_idx;
    logic [16:0]     r_p2_cur;
    logic [16:0]     r_p2_tgt;
    logic [15:0]     r_p2_mag;
    logic            r_p2_neg;
    logic            r_p2_snap;
    logic            r_p3_valid;
    logic [HW-1:0]   r_p3_idx;
    logic [16:0]     r_p3_cur;
    logic [16:0]     r_p3_tgt;
    logic [16:0]     r_p3_step;
    logic            r_p3_neg;
    logic            r_p3_snap;

    logic in_ready, issue, clear_we, load_out, issue_last, accept;

    logic [HW-1:0]  raddr;
    logic [16:0]    cur_rdata, tgt_rdata;
    logic           cur_we, tgt_we;
    logic [HW-1:0]  waddr;
    logic [16:0]    cur_wdata, tgt_wdata;

    logic [IXW-1:0] ix_ext;
    logic           ix_in_range;
    logic [23:0]    rate_prod;
    logic [16:0]    factor_sat;

    logic [3:0]     dig_val;
    logic [4:0]     gpos;
    t_pair          gpair;
    logic [16:0]    glyph_angle;

    logic signed [17:0] d_raw, d_wrap;
    logic [16:0]        p1_tgt;
    logic [15:0]        p1_mag;
    logic [32:0]        prod;
    logic [17:0]        sum_fwd, sum_back;
    logic [16:0]        p3_new;
    logic               p3_moving;
    logic [8:0]         count_sat;

    assign issue_last  = (r_issue_idx == HW'(HAND_TOTAL - 1));
    assign accept      = in_ready && i_in.valid;
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    assign ix_ext      = IXW'(i_in.hand_index);
    assign ix_in_range = (ix_ext < IXW'(HAND_TOTAL));

    assign rate_prod  = 24'(r_rate) * 24'(i_in.frame_time);
    assign factor_sat = (rate_prod > 24'(UNIT_Q16)) ? UNIT_Q16 : rate_prod[16:0];

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        issue    = 1'b0;
        clear_we = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                clear_we = 1'b1;
                if (issue_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    case (t_cmd'(i_in.command))
                        CMD_SET, CMD_TICK: n_state = ST_SWEEP;
                        CMD_READ:          n_state = ST_READ;
                        default:           n_state = ST_RESULT;
                    endcase
                end
            end
            ST_SWEEP: begin
                issue = 1'b1;
                if (issue_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_p1_valid && !r_p2_valid && !r_p3_valid) begin
                    n_state = ST_RESULT;
                end
            end
            ST_READ: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // glyph target of the hand being issued
    always_comb begin
        dig_val = DIGIT_BLANK;
        for (int k = 0; k < 6; k++) begin
            if (int'(r_dig) == k) begin
                dig_val = r_digits[k];
            end
        end
        if (int'(r_row) >= 6 || int'(r_col) >= 4) begin
            dig_val = DIGIT_BLANK;
        end
        gpos        = 5'(int'(r_row) * 4 + int'(r_col));
        gpair       = glyph_pair(dig_val, gpos);
        glyph_angle = r_hand ? gpair.ang_b : gpair.ang_a;
    end

    // stage 1: shorter-way difference
    always_comb begin
        p1_tgt = (r_cmd == CMD_SET) ? r_p1_glyph : tgt_rdata;
        d_raw  = $signed({1'b0, tgt_rdata}) - $signed({1'b0, cur_rdata});
        if (d_raw >= S_HALF) begin
            d_wrap = d_raw - S_FULL;
        end else if (d_raw < -S_HALF) begin
            d_wrap = d_raw + S_FULL;
        end else begin
            d_wrap = d_raw;
        end
        p1_mag = d_wrap[17] ? 16'(-d_wrap) : 16'(d_wrap);
    end

    // stage 2: scaled step
    assign prod = 33'(r_p2_mag) * 33'(r_factor);

    // stage 3: new angle, wrapped
    always_comb begin
        sum_fwd  = {1'b0, r_p3_cur} + {1'b0, r_p3_step};
        sum_back = {1'b0, r_p3_cur} + FULL_TURN - {1'b0, r_p3_step};
        if (r_p3_snap) begin
            p3_new = r_p3_tgt;
        end else if (r_p3_neg) begin
            p3_new = (sum_back >= FULL_TURN) ? 17'(sum_back - FULL_TURN) : sum_back[16:0];
        end else begin
            p3_new = (sum_fwd >= FULL_TURN) ? 17'(sum_fwd - FULL_TURN) : sum_fwd[16:0];
        end
        if (r_cmd == CMD_SET) begin
            p3_moving = (r_p3_cur != r_p3_tgt);
        end else begin
            p3_moving = (p3_new != r_p3_tgt);
        end
    end

    assign count_sat = (int'(r_count) > 511) ? 9'd511 : 9'(r_count);

    // memory ports
    assign raddr     = (r_state == ST_IDLE) ? HW'(ix_ext) : r_issue_idx;
    assign waddr     = clear_we ? r_issue_idx : r_p3_idx;
    assign cur_we    = clear_we || (r_p3_valid && r_cmd == CMD_TICK);
    assign tgt_we    = clear_we || (r_p3_valid && r_cmd == CMD_SET);
    assign cur_wdata = clear_we ? ANGLE_RESET : p3_new;
    assign tgt_wdata = clear_we ? ANGLE_RESET : r_p3_tgt;

    cocha_ram #(
        .WIDTH (ANGLE_W),
        .DEPTH (HAND_TOTAL)
    ) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (cur_we),
        .i_waddr (waddr),
        .i_wdata (cur_wdata),
        .i_raddr (raddr),
        .o_rdata (cur_rdata)
    );

    cocha_ram #(
        .WIDTH (ANGLE_W),
        .DEPTH (HAND_TOTAL)
    ) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (tgt_we),
        .i_waddr (waddr),
        .i_wdata (tgt_wdata),
        .i_raddr (raddr),
        .o_rdata (tgt_rdata)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        r_p1_idx   <= r_issue_idx;
        r_p1_glyph <= glyph_angle;
        r_p2_idx   <= r_p1_idx;
        r_p2_cur   <= cur_rdata;
        r_p2_tgt   <= p1_tgt;
        r_p2_mag   <= p1_mag;
        r_p2_neg   <= d_wrap[17];
        r_p2_snap  <= (p1_mag < SNAP_LIMIT);
        r_p3_idx   <= r_p2_idx;
        r_p3_cur   <= r_p2_cur;
        r_p3_tgt   <= r_p2_tgt;
        r_p3_step  <= prod[32:16];
        r_p3_neg   <= r_p2_neg;
        r_p3_snap  <= r_p2_snap;
        if (accept) begin
            r_cmd       <= t_cmd'(i_in.command);
            r_factor    <= factor_sat;
            r_digits[0] <= tens_of({1'b0, i_in.hours});
            r_digits[1] <= ones_of({1'b0, i_in.hours});
            r_digits[2] <= tens_of(i_in.minutes);
            r_digits[3] <= ones_of(i_in.minutes);
            r_digits[4] <= tens_of(i_in.seconds);
            r_digits[5] <= ones_of(i_in.seconds);
            r_angle     <= '0;
            r_read_ok   <= ix_in_range;
        end
        if (r_state == ST_READ) begin
            r_angle <= r_read_ok ? cur_rdata : '0;
        end
        if (load_out) begin
            r_out_angle  <= r_angle;
            r_out_moving <= count_sat;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= RATE_RESET;
            r_issue_idx <= '0;
            r_dig       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_hand      <= 1'b0;
            r_count     <= '0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_rate <= i_cfg.animation_rate;
            end
            if (accept) begin
                r_issue_idx <= '0;
                r_dig       <= '0;
                r_row       <= '0;
                r_col       <= '0;
                r_hand      <= 1'b0;
                if (t_cmd'(i_in.command) == CMD_SET || t_cmd'(i_in.command) == CMD_TICK) begin
                    r_count <= '0;
                end
            end
            if (clear_we || issue) begin
                r_issue_idx <= r_issue_idx + HW'(1);
            end
            // walk digit, row, column, hand alongside the flat index
            if (issue) begin
                r_hand <= ~r_hand;
                if (r_hand) begin
                    if (r_col == CW'(GLYPH_COLUMNS - 1)) begin
                        r_col <= '0;
                        if (r_row == RW'(GLYPH_ROWS - 1)) begin
                            r_row <= '0;
                            r_dig <= r_dig + DW'(1);
                        end else begin
                            r_row <= r_row + RW'(1);
                        end
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
            end
            r_p1_valid <= issue;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            if (r_p3_valid && p3_moving) begin
                r_count <= r_count + CNTW'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.hand_angle   = r_out_angle;
    assign o_out.hands_moving = r_out_moving;

    `COCHA_ASSERT(a_idle_pipe_empty, i_clk, i_rst_n, r_state == ST_IDLE, !r_p1_valid && !r_p2_valid && !r_p3_valid)
    `COCHA_ASSERT(a_count_bound, i_clk, i_rst_n, 1'b1, int'(r_count) <= HAND_TOTAL)
    `COCHA_ASSERT_NEXT(a_sweep_ends, i_clk, i_rst_n, r_state == ST_SWEEP && issue_last, r_state == ST_DRAIN)

endmodule
